// ===== sv/call_stack_time_profiler_defines.svh =====
// Assertion macros for the call stack time profiler
`ifndef CALL_STACK_TIME_PROFILER_DEFINES_SVH
`define CALL_STACK_TIME_PROFILER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CSTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cstp_pkg.sv =====
// Types and constants shared by the call stack time profiler
package cstp_pkg;

  localparam int ID_W    = 6;
  localparam int ID_CNT  = 2 ** ID_W;
  localparam int TOTAL_W = 48;

  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_EXIT  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_READ   = 3'd2,
    S_EX_STK = 3'd3,
    S_EX_TOT = 3'd4,
    S_EX_PAR = 3'd5
  } state_t;

endpackage

// ===== sv/cstp_ram.sv =====
// Generic RAM: one write port, two registered read ports
module cstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/call_stack_time_profiler.sv =====
// Call stack time profiler: shadow call stack with inclusive/exclusive totals
//
//  channel  ports                                        handshake
//  in       in_func, in_function_id, in_timestamp        start / busy
//  out      out_status, out_exited_id, out_elapsed,      out_valid, one-cycle strobe
//           out_inclusive_total, out_exclusive_total,
//           out_depth
//
// Enter, no-op and empty-stack exit finish in S_IDLE, read goes through S_READ,
// exit through S_EX_STK, S_EX_TOT and, when a parent with a different id is
// charged, S_EX_PAR (one write port on the totals memory). The result beat is
// registered from S_IDLE, S_READ or S_EX_TOT. After reset busy stays high while
// the totals memory is cleared one entry a cycle. The receiver cannot stall.
`include "call_stack_time_profiler_defines.svh"

module call_stack_time_profiler #(
  parameter int STACK_DEPTH = 16,
  parameter int NUM_FUNCS   = 64,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_func,
  input  logic [cstp_pkg::ID_W-1:0]             in_function_id,
  input  logic [TIME_WIDTH-1:0]                 in_timestamp,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [cstp_pkg::ID_W-1:0]             out_exited_id,
  output logic [TIME_WIDTH-1:0]                 out_elapsed,
  output logic [cstp_pkg::TOTAL_W-1:0]          out_inclusive_total,
  output logic signed [cstp_pkg::TOTAL_W-1:0]   out_exclusive_total,
  output logic [$clog2(STACK_DEPTH+1)-1:0]      out_depth
);

  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int FW    = $clog2(NUM_FUNCS);
  localparam int TW    = cstp_pkg::TOTAL_W;
  localparam int STK_W = FW + TIME_WIDTH;
  localparam int TOT_W = 2 * TW;

  cstp_pkg::state_t state_r, state_nxt;

  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [FW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [FW-1:0]         f_r, f_nxt;
  logic [FW-1:0]         p_r, p_nxt;
  logic [TIME_WIDTH-1:0] el_r, el_nxt;
  logic                  par_r, par_nxt;
  logic                  self_r, self_nxt;
  logic [TOT_W-1:0]      pw_data_r, pw_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [cstp_pkg::ID_W-1:0] out_exited_id_r, out_exited_id_nxt;
  logic [TIME_WIDTH-1:0] out_elapsed_r, out_elapsed_nxt;
  logic [TW-1:0]         out_inc_r, out_inc_nxt;
  logic [TW-1:0]         out_exc_r, out_exc_nxt;
  logic [SPW-1:0]        out_depth_r, out_depth_nxt;

  logic                  stk_we;
  logic [SAW-1:0]        stk_waddr, stk_raddr_a, stk_raddr_b;
  logic [STK_W-1:0]      stk_wdata, stk_rdata_a, stk_rdata_b;
  logic                  tot_we;
  logic [FW-1:0]         tot_waddr, tot_raddr_a, tot_raddr_b;
  logic [TOT_W-1:0]      tot_wdata, tot_rdata_a, tot_rdata_b;

  logic                  accept;
  cstp_pkg::kind_t       kind;
  logic [FW-1:0]         id_lut [cstp_pkg::ID_CNT];
  logic [FW-1:0]         id_wrap;
  logic [SPW-1:0]        sp_m1, sp_m2;
  logic [FW-1:0]         top_id, par_id;
  logic [TIME_WIDTH-1:0] top_start;
  logic [TW-1:0]         el_ext, inc_f, exc_f, inc_p, exc_p, exc_f_new, inc_f_new;

  for (genvar g = 0; g < cstp_pkg::ID_CNT; g++) begin : g_id_lut
    assign id_lut[g] = FW'(g % NUM_FUNCS);
  end

  assign accept  = start && !busy;
  assign kind    = cstp_pkg::kind_t'(in_func);
  assign id_wrap = id_lut[in_function_id];
  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);

  assign top_id    = stk_rdata_a[STK_W-1:TIME_WIDTH];
  assign top_start = stk_rdata_a[TIME_WIDTH-1:0];
  assign par_id    = stk_rdata_b[STK_W-1:TIME_WIDTH];

  assign el_ext    = TW'(el_r);
  assign inc_f     = tot_rdata_a[TOT_W-1:TW];
  assign exc_f     = tot_rdata_a[TW-1:0];
  assign inc_p     = tot_rdata_b[TOT_W-1:TW];
  assign exc_p     = tot_rdata_b[TW-1:0];
  assign inc_f_new = inc_f + el_ext;
  assign exc_f_new = self_r ? exc_f : exc_f + el_ext;

  cstp_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .raddr_a (stk_raddr_a),
    .rdata_a (stk_rdata_a),
    .raddr_b (stk_raddr_b),
    .rdata_b (stk_rdata_b)
  );

  cstp_ram #(.WIDTH(TOT_W), .DEPTH(NUM_FUNCS)) u_total_ram (
    .clk     (clk),
    .we      (tot_we),
    .waddr   (tot_waddr),
    .wdata   (tot_wdata),
    .raddr_a (tot_raddr_a),
    .rdata_a (tot_rdata_a),
    .raddr_b (tot_raddr_b),
    .rdata_b (tot_rdata_b)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cstp_pkg::S_CLEAR: begin
        if (clr_addr_r == FW'(NUM_FUNCS - 1)) begin
          state_nxt = cstp_pkg::S_IDLE;
        end
      end
      cstp_pkg::S_IDLE: begin
        if (accept && kind == cstp_pkg::KIND_READ) begin
          state_nxt = cstp_pkg::S_READ;
        end else if (accept && kind == cstp_pkg::KIND_EXIT && sp_r != '0) begin
          state_nxt = cstp_pkg::S_EX_STK;
        end
      end
      cstp_pkg::S_READ:   state_nxt = cstp_pkg::S_IDLE;
      cstp_pkg::S_EX_STK: state_nxt = cstp_pkg::S_EX_TOT;
      cstp_pkg::S_EX_TOT: state_nxt = par_r ? cstp_pkg::S_EX_PAR : cstp_pkg::S_IDLE;
      cstp_pkg::S_EX_PAR: state_nxt = cstp_pkg::S_IDLE;
      default:            state_nxt = cstp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sp_nxt            = sp_r;
    clr_addr_nxt      = clr_addr_r;
    now_nxt           = now_r;
    f_nxt             = f_r;
    p_nxt             = p_r;
    el_nxt            = el_r;
    par_nxt           = par_r;
    self_nxt          = self_r;
    pw_data_nxt       = pw_data_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = cstp_pkg::STAT_OK;
    out_exited_id_nxt = '0;
    out_elapsed_nxt   = '0;
    out_inc_nxt       = '0;
    out_exc_nxt       = '0;
    out_depth_nxt     = out_depth_r;
    stk_we            = 1'b0;
    stk_waddr         = sp_r[SAW-1:0];
    stk_wdata         = {id_wrap, in_timestamp};
    stk_raddr_a       = sp_m1[SAW-1:0];
    stk_raddr_b       = sp_m2[SAW-1:0];
    tot_we            = 1'b0;
    tot_waddr         = f_r;
    tot_wdata         = '0;
    tot_raddr_a       = f_r;
    tot_raddr_b       = p_r;
    case (state_r)
      cstp_pkg::S_CLEAR: begin
        tot_we       = 1'b1;
        tot_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + FW'(1);
      end
      cstp_pkg::S_IDLE: begin
        if (accept) begin
          case (kind)
            cstp_pkg::KIND_ENTER: begin
              out_valid_nxt = 1'b1;
              if (sp_r == SPW'(STACK_DEPTH)) begin
                out_status_nxt = cstp_pkg::STAT_OVERFLOW;
                out_depth_nxt  = sp_r;
              end else begin
                stk_we        = 1'b1;
                sp_nxt        = sp_r + SPW'(1);
                out_depth_nxt = sp_r + SPW'(1);
              end
            end
            cstp_pkg::KIND_EXIT: begin
              now_nxt = in_timestamp;
              if (sp_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = cstp_pkg::STAT_UNDERFLOW;
                out_depth_nxt  = sp_r;
              end
            end
            cstp_pkg::KIND_READ: begin
              tot_raddr_a = id_wrap;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_depth_nxt = sp_r;
            end
          endcase
        end
      end
      cstp_pkg::S_READ: begin
        out_valid_nxt = 1'b1;
        out_inc_nxt   = inc_f;
        out_exc_nxt   = exc_f;
        out_depth_nxt = sp_r;
      end
      cstp_pkg::S_EX_STK: begin
        f_nxt       = top_id;
        p_nxt       = par_id;
        el_nxt      = now_r - top_start;
        par_nxt     = (sp_r > SPW'(1)) && (top_id != par_id);
        self_nxt    = (sp_r > SPW'(1)) && (top_id == par_id);
        sp_nxt      = sp_m1;
        tot_raddr_a = top_id;
        tot_raddr_b = par_id;
      end
      cstp_pkg::S_EX_TOT: begin
        tot_we            = 1'b1;
        tot_waddr         = f_r;
        tot_wdata         = {inc_f_new, exc_f_new};
        pw_data_nxt       = {inc_p, exc_p - el_ext};
        out_valid_nxt     = 1'b1;
        out_exited_id_nxt = cstp_pkg::ID_W'(f_r);
        out_elapsed_nxt   = el_r;
        out_inc_nxt       = inc_f_new;
        out_exc_nxt       = exc_f_new;
        out_depth_nxt     = sp_r;
      end
      cstp_pkg::S_EX_PAR: begin
        tot_we    = 1'b1;
        tot_waddr = p_r;
        tot_wdata = pw_data_r;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cstp_pkg::S_CLEAR;
      sp_r        <= '0;
      clr_addr_r  <= '0;
      par_r       <= 1'b0;
      self_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_depth_r <= '0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      clr_addr_r  <= clr_addr_nxt;
      par_r       <= par_nxt;
      self_r      <= self_nxt;
      out_valid_r <= out_valid_nxt;
      out_depth_r <= out_depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r           <= now_nxt;
    f_r             <= f_nxt;
    p_r             <= p_nxt;
    el_r            <= el_nxt;
    pw_data_r       <= pw_data_nxt;
    out_status_r    <= out_status_nxt;
    out_exited_id_r <= out_exited_id_nxt;
    out_elapsed_r   <= out_elapsed_nxt;
    out_inc_r       <= out_inc_nxt;
    out_exc_r       <= out_exc_nxt;
  end

  assign busy                = (state_r != cstp_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_exited_id       = out_exited_id_r;
  assign out_elapsed         = out_elapsed_r;
  assign out_inclusive_total = out_inc_r;
  assign out_exclusive_total = out_exc_r;
  assign out_depth           = out_depth_r;

  `CSTP_ASSERT_NOW(a_sp_bound, 1'b1, sp_r <= SPW'(STACK_DEPTH), "stack pointer past depth")
  `CSTP_ASSERT_NEXT(a_exit_beat, accept && kind == cstp_pkg::KIND_EXIT && sp_r != '0, ##2 out_valid_r, "exit beat missing")
  `CSTP_ASSERT_NEXT(a_push, accept && kind == cstp_pkg::KIND_ENTER && sp_r != SPW'(STACK_DEPTH), sp_r == $past(sp_r) + SPW'(1), "push did not advance stack pointer")
  `CSTP_ASSERT_NOW(a_clear_quiet, state_r == cstp_pkg::S_CLEAR, !out_valid_r && busy, "beat during clear")

endmodule
